// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/ili_pkg.sv -----
// Types, constants and sizes shared by the indexed list store.
package ili_pkg;

    // Size of the store, in entries.
    localparam int CAPACITY = 16;

    // Fixed port widths.
    localparam int CMD_W   = 3;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Widths derived from the store size.
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_INS_AT   = 3'd2,
        CMD_DEL_HEAD = 3'd3,
        CMD_DEL_TAIL = 3'd4,
        CMD_DEL_AT   = 3'd5,
        CMD_READ     = 3'd6
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Shift control broadcast to every cell of the row.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [CMP_W-1:0] at;
    } shift_t;

    // Decoded command.
    typedef struct packed {
        shift_t           shift;
        logic             do_rd;
        status_t          status;
        logic [CNT_W-1:0] count_next;
    } ctrl_t;

endpackage

// ----- hw/rtl/ili_cell.sv -----
// One storage cell of the list row, shifting toward or away from the head.
module ili_cell (
    input  logic                             clk,
    input  logic [ili_pkg::CMP_W-1:0]        idx,
    input  ili_pkg::shift_t                  shift,
    input  logic signed [ili_pkg::VAL_W-1:0] new_value,
    input  logic signed [ili_pkg::VAL_W-1:0] left_value,
    input  logic signed [ili_pkg::VAL_W-1:0] right_value,
    output logic signed [ili_pkg::VAL_W-1:0] value
);

    logic signed [ili_pkg::VAL_W-1:0] value_reg;
    logic signed [ili_pkg::VAL_W-1:0] value_next;

    // On insert the cell at the gap takes the new value and cells behind it
    // take their left neighbor; on delete cells from the gap on take their right one.
    always_comb
    begin
        value_next = value_reg;
        if (shift.ins)
        begin
            if (idx == shift.at)
            begin
                value_next = new_value;
            end
            else if (idx > shift.at)
            begin
                value_next = left_value;
            end
        end
        else if (shift.del)
        begin
            if (idx >= shift.at)
            begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- hw/rtl/ili_decode.sv -----
// Command decode: checks the index against the fill count and picks the shift.
module ili_decode (
    input  logic [ili_pkg::CMD_W-1:0] cmd,
    input  logic [ili_pkg::POS_W-1:0] position,
    input  logic [ili_pkg::CNT_W-1:0] count_cur,
    output ili_pkg::ctrl_t            ctrl
);

    logic [ili_pkg::CMP_W-1:0] pos_ext;
    logic [ili_pkg::CMP_W-1:0] cnt_ext;
    logic [ili_pkg::CMP_W-1:0] ins_at;
    logic                      is_full;
    logic                      is_empty;

    assign pos_ext  = ili_pkg::CMP_W'(position);
    assign cnt_ext  = ili_pkg::CMP_W'(count_cur);
    assign is_full  = (count_cur == ili_pkg::CNT_W'(ili_pkg::CAPACITY));
    assign is_empty = (count_cur == '0);

    always_comb
    begin
        ctrl            = '0;
        ctrl.status     = ili_pkg::ST_OK;
        ctrl.count_next = count_cur;
        ins_at          = pos_ext;
        case (ili_pkg::cmd_t'(cmd))
            ili_pkg::CMD_INS_HEAD, ili_pkg::CMD_INS_TAIL, ili_pkg::CMD_INS_AT:
            begin
                if (ili_pkg::cmd_t'(cmd) == ili_pkg::CMD_INS_HEAD)
                begin
                    ins_at = '0;
                end
                else if (ili_pkg::cmd_t'(cmd) == ili_pkg::CMD_INS_TAIL)
                begin
                    ins_at = cnt_ext;
                end
                ctrl.shift.at = ins_at;
                if (ins_at > cnt_ext)
                begin
                    ctrl.status = ili_pkg::ST_BAD_INDEX;
                end
                else if (is_full)
                begin
                    ctrl.status = ili_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.shift.ins  = 1'b1;
                    ctrl.count_next = count_cur + 1'b1;
                end
            end
            ili_pkg::CMD_DEL_HEAD, ili_pkg::CMD_DEL_TAIL:
            begin
                if (is_empty)
                begin
                    ctrl.status = ili_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.shift.del  = 1'b1;
                    ctrl.shift.at   = (ili_pkg::cmd_t'(cmd) == ili_pkg::CMD_DEL_HEAD) ?
                                      '0 : (cnt_ext - 1'b1);
                    ctrl.count_next = count_cur - 1'b1;
                end
            end
            ili_pkg::CMD_DEL_AT:
            begin
                ctrl.shift.at = pos_ext;
                if (pos_ext >= cnt_ext)
                begin
                    ctrl.status = ili_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    ctrl.shift.del  = 1'b1;
                    ctrl.count_next = count_cur - 1'b1;
                end
            end
            ili_pkg::CMD_READ:
            begin
                ctrl.shift.at = pos_ext;
                if (pos_ext >= cnt_ext)
                begin
                    ctrl.status = ili_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    ctrl.do_rd = 1'b1;
                end
            end
            default:
            begin
                ctrl.status = ili_pkg::ST_OK;
            end
        endcase
    end

endmodule

// ----- hw/rtl/indexed_list_insert_delete.sv -----
// Top level of the indexed list store: decode, row of cells and result registers.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit values,
// entry 0 being the head, in a row of identical cells. It takes one command
// item in every clock cycle: busy is always low, so an item is accepted at
// every rising edge at which start is high. Each item gives exactly one
// result, shown on status, read_value and count with done high for the single
// cycle that follows the accepting edge; the receiver cannot stall it, so it
// must take the result in that cycle. That rate comes
// from the cell row: every cell compares its own place with the command's
// index and, in the same cycle, keeps its value, takes the inserted value or
// takes the value of its left or right neighbor, so an insert or delete
// anywhere in the list completes at the accepting edge. A read picks the addressed cell
// through a multiplexer in that same cycle. count is the number of entries
// after the command. An insert past the end or a delete or read at an absent
// index reports an invalid index with read_value all ones; deleting at the
// head or tail of an empty list reports list empty; an insert into a full
// store reports list full. In each of those cases the list does not change.
// The unused command code does nothing and reports ok.
module indexed_list_insert_delete (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ili_pkg::CMD_W-1:0]        cmd,
    input  logic [ili_pkg::POS_W-1:0]        position,
    input  logic signed [ili_pkg::VAL_W-1:0] item_value,
    output logic                             done,
    output logic [ili_pkg::STAT_W-1:0]       status,
    output logic signed [ili_pkg::VAL_W-1:0] read_value,
    output logic [ili_pkg::COUNT_W-1:0]      count
);

    logic                             accept;
    ili_pkg::ctrl_t                   ctrl;
    ili_pkg::shift_t                  cell_shift;
    logic signed [ili_pkg::VAL_W-1:0] cell_value [ili_pkg::CAPACITY];
    logic signed [ili_pkg::VAL_W-1:0] read_pick;

    logic [ili_pkg::CNT_W-1:0]        count_reg;
    logic [ili_pkg::CNT_W-1:0]        count_next;
    logic                             done_reg;
    ili_pkg::status_t                 status_reg;
    logic signed [ili_pkg::VAL_W-1:0] read_value_reg;
    logic signed [ili_pkg::VAL_W-1:0] read_value_next;

    // Every cell finishes its shift in the accepting cycle, so no item waits.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    ili_decode u_decode (
        .cmd       (cmd),
        .position  (position),
        .count_cur (count_reg),
        .ctrl      (ctrl)
    );

    // The row only moves on an accepted item.
    always_comb
    begin
        cell_shift     = ctrl.shift;
        cell_shift.ins = ctrl.shift.ins && accept;
        cell_shift.del = ctrl.shift.del && accept;
    end

    // Cell 0 has no left neighbor and the last cell no right neighbor. The
    // head only takes a left value when the index is below it, which never
    // happens, and the tail's value after a delete lies past the fill count.
    for (genvar i = 0; i < ili_pkg::CAPACITY; i++)
    begin : g_cell
        logic signed [ili_pkg::VAL_W-1:0] left_value;
        logic signed [ili_pkg::VAL_W-1:0] right_value;

        if (i == 0)
        begin : g_head
            assign left_value = item_value;
        end
        else
        begin : g_body_left
            assign left_value = cell_value[i-1];
        end

        if (i == ili_pkg::CAPACITY - 1)
        begin : g_tail
            assign right_value = '0;
        end
        else
        begin : g_body_right
            assign right_value = cell_value[i+1];
        end

        ili_cell u_cell (
            .clk         (clk),
            .idx         (ili_pkg::CMP_W'(i)),
            .shift       (cell_shift),
            .new_value   (item_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i])
        );
    end

    // A read only reaches cells below the fill count, which were written.
    assign read_pick = cell_value[ctrl.shift.at[ili_pkg::IDX_W-1:0]];

    always_comb
    begin
        if (ctrl.status == ili_pkg::ST_BAD_INDEX)
        begin
            read_value_next = '1;
        end
        else if (ctrl.do_rd)
        begin
            read_value_next = read_pick;
        end
        else
        begin
            read_value_next = '0;
        end
    end

    assign count_next = accept ? ctrl.count_next : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // The result payload is only looked at while done is high.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= ctrl.status;
            read_value_reg <= read_value_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign count      = ili_pkg::COUNT_W'(count_reg);

endmodule

// ----- hw/rtl/ili_checker.sv -----
// Port-level checks of the indexed list store, bound to its top level.
`include "assert_macros.svh"

module ili_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic [ili_pkg::CMD_W-1:0]        cmd,
    input logic [ili_pkg::POS_W-1:0]        position,
    input logic signed [ili_pkg::VAL_W-1:0] item_value,
    input logic                             done,
    input logic [ili_pkg::STAT_W-1:0]       status,
    input logic signed [ili_pkg::VAL_W-1:0] read_value,
    input logic [ili_pkg::COUNT_W-1:0]      count
);

    // Every accepted item gives one result in the next cycle, and only then.
    `ASSERT_NEXT(a_result_follows, clk, rst_n, start && !busy, done)
    `ASSERT_NEXT(a_no_stray_result, clk, rst_n, !(start && !busy), !done)

    // An invalid index always reads back as all ones.
    `ASSERT_IMPLIES(a_bad_index_value, clk, rst_n,
        done && status == ili_pkg::ST_BAD_INDEX, read_value == '1)

    // An empty-list refusal can only come with an empty list.
    `ASSERT_IMPLIES(a_empty_count, clk, rst_n,
        done && status == ili_pkg::ST_EMPTY, count == '0)

    // With back-to-back results, a failed command leaves the count as the previous result showed it.
    `ASSERT_IMPLIES(a_refusal_keeps_count, clk, rst_n,
        done && $past(done) && status != ili_pkg::ST_OK, count == $past(count))

endmodule

bind indexed_list_insert_delete ili_checker u_ili_checker (.*);
